@@ rtl/core/rtp_nack_retransmit_policy_unit_defines.svh @@
// Assertion macros used by the RTP NACK retransmit policy RTL.
// No dependencies; users need clk_i and rst_ni in scope.
`ifndef RTP_NACK_RETRANSMIT_POLICY_UNIT_DEFINES_SVH
`define RTP_NACK_RETRANSMIT_POLICY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RNRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RNRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rnrp_pkg.sv @@
// Package for the RTP NACK retransmit policy unit: types, codes, constants.
// No dependencies.
package rnrp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned PT_W    = 7;
  localparam int unsigned RTT_W   = 16;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned OUT_W   = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_TPM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_TPM    = 3'd5;

  // Register reset values
  localparam logic [PT_W-1:0]  VIDEO_CODE_RST = 7'd96;
  localparam logic [PT_W-1:0]  AUDIO_CODE_RST = 7'd97;
  localparam logic [CFG_W-1:0] VIDEO_TPM_RST  = 16'd90;
  localparam logic [CFG_W-1:0] AUDIO_TPM_RST  = 16'd48;

  // Outcome codes
  localparam logic [OUT_W-1:0] OC_RECORDED = 3'd0;
  localparam logic [OUT_W-1:0] OC_RESEND   = 3'd1;
  localparam logic [OUT_W-1:0] OC_TOO_OLD  = 3'd2;
  localparam logic [OUT_W-1:0] OC_MISSING  = 3'd3;
  localparam logic [OUT_W-1:0] OC_STALE    = 3'd4;
  localparam logic [OUT_W-1:0] OC_LIMIT    = 3'd5;
  localparam logic [OUT_W-1:0] OC_TOO_SOON = 3'd6;

  // Policy constants
  localparam logic [4:0]       STALE_SPAN  = 5'd20;
  localparam logic [CNT_W-1:0] LIMIT_KEY   = 4'd7;
  localparam logic [CNT_W-1:0] LIMIT_VIDEO = 4'd5;
  localparam logic [CNT_W-1:0] LIMIT_OTHER = 4'd9;
  localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

  // floor(x/3) = (x * RTT_RECIP) >> RTT_SHIFT, exact for x < 2^17
  localparam logic [16:0]      RTT_RECIP = 17'd43691;
  localparam int unsigned      RTT_SHIFT = 17;

  typedef struct packed {
    logic [CFG_W-1:0] max_age;
    logic [CFG_W-1:0] min_interval;
    logic [PT_W-1:0]  video_code;
    logic [PT_W-1:0]  audio_code;
    logic [CFG_W-1:0] video_tpm;
    logic [CFG_W-1:0] audio_tpm;
  } rnrp_cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   media_timestamp;
    logic              packet_found;
    logic [PT_W-1:0]   payload_code;
    logic              key_flag;
    logic [RTT_W-1:0]  rtt_ms;
    logic [TIME_W-1:0] now_ms;
  } rnrp_item_t;

  typedef struct packed {
    logic             resend;
    logic [OUT_W-1:0] outcome;
    logic [CNT_W-1:0] attempts;
  } rnrp_result_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  tag;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] stamp;
  } rnrp_entry_t;

  typedef struct packed {
    logic clr_en;   // clear one valid bit
    logic capture;  // request accepted, latch it
    logic addr;     // reduce slot, issue table read
    logic eval;     // decide, write back, load result
  } rnrp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } rnrp_sts_t;

endpackage

@@ rtl/core/rnrp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond rnrp_pkg defaults.
module rnrp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = rnrp_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rnrp_ctrl.sv @@
// Controller for the RTP NACK retransmit policy unit: clear pass, item
// sequencing and the output register valid. Uses rnrp_pkg and the defines.
`include "rtp_nack_retransmit_policy_unit_defines.svh"

module rnrp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  rnrp_pkg::rnrp_sts_t sts_i,
  output rnrp_pkg::rnrp_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;
  localparam logic [1:0] ST_EVAL  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o.clr_en  = (state_q == ST_CLEAR);
    cmd_o.capture = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.addr    = (state_q == ST_ADDR);
    cmd_o.eval    = (state_q == ST_EVAL) && can_load;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.eval) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `RNRP_ASSERT_NEXT(a_accept_to_addr, cmd_o.capture, state_q == ST_ADDR, "accept did not start addr")
  `RNRP_ASSERT_NEXT(a_addr_to_eval, state_q == ST_ADDR, state_q == ST_EVAL, "addr not followed by eval")
  `RNRP_ASSERT_NEXT(a_result_held, out_valid_q && !m_ready_i, out_valid_q, "pending result dropped")
  `RNRP_ASSERT_NEXT(a_eval_loads, cmd_o.eval, out_valid_q && state_q == ST_IDLE, "eval did not load result")

endmodule

@@ rtl/core/rnrp_dp.sv @@
// Datapath for the RTP NACK retransmit policy unit: request registers,
// checks, table RAMs and result register. Uses rnrp_pkg and rnrp_ram.
module rnrp_dp #(
  parameter int unsigned TABLE_DEPTH = rnrp_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rnrp_pkg::rnrp_cmd_t    cmd_i,
  input  rnrp_pkg::rnrp_cfg_t    cfg_i,
  input  rnrp_pkg::rnrp_item_t   item_i,
  output rnrp_pkg::rnrp_sts_t    sts_o,
  output rnrp_pkg::rnrp_result_t result_o
);

  // seq / TABLE_DEPTH = (seq * SLOT_RECIP) >> 32, exact for 16-bit seq
  localparam logic [63:0] SLOT_RECIP_W =
    ((64'd1 << 32) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [32:0] SLOT_RECIP = SLOT_RECIP_W[32:0];

  rnrp_pkg::rnrp_item_t   item_q;
  rnrp_pkg::rnrp_result_t result_q, result_d;

  logic [rnrp_pkg::SEQ_W-1:0]  newest_q, newest_d;
  logic [rnrp_pkg::TS_W-1:0]   last_ts_q, last_ts_d;
  logic [IDX_W-1:0]            clr_cnt_q;

  logic [15:0]                 quot_q;
  logic                        too_old_q, stale_q;
  logic [rnrp_pkg::CNT_W-1:0]  limit_q;
  logic [IDX_W-1:0]            slot_q;
  logic [rnrp_pkg::RTT_W-1:0]  interval_q;

  // capture stage
  logic [48:0]                 slot_prod;
  logic [rnrp_pkg::SEQ_W-1:0]  age_dist;
  logic                        too_old_d;
  logic [rnrp_pkg::CFG_W-1:0]  base;
  logic [rnrp_pkg::TS_W-1:0]   ts_diff, ts_dist;
  logic [20:0]                 stale_thr;
  logic                        stale_d;
  logic [rnrp_pkg::CNT_W-1:0]  limit_d;

  always_comb begin
    slot_prod = 49'(item_i.seq) * 49'(SLOT_RECIP);
    age_dist  = newest_q - item_i.seq;
    too_old_d = (cfg_i.max_age != '0) && (age_dist > cfg_i.max_age);
    base      = (item_i.payload_code == cfg_i.audio_code) ? cfg_i.audio_tpm
                                                          : cfg_i.video_tpm;
    ts_diff   = last_ts_q - item_i.media_timestamp;
    ts_dist   = ts_diff[31] ? (32'd0 - ts_diff) : ts_diff;
    stale_thr = 21'(base) * 21'(rnrp_pkg::STALE_SPAN);
    stale_d   = (base != '0) && (ts_dist >= 32'(stale_thr));
    if (item_i.payload_code == cfg_i.video_code) begin
      limit_d = item_i.key_flag ? rnrp_pkg::LIMIT_KEY : rnrp_pkg::LIMIT_VIDEO;
    end else begin
      limit_d = rnrp_pkg::LIMIT_OTHER;
    end
  end

  // address stage
  logic [31:0]                 slot_mul;
  logic [15:0]                 slot_rem;
  logic [IDX_W-1:0]            slot_d;
  logic [33:0]                 rtt_prod, rtt_scaled;
  logic [rnrp_pkg::RTT_W-1:0]  rtt_iv, interval_d;

  always_comb begin
    slot_mul   = 32'(quot_q) * 32'(TABLE_DEPTH);
    slot_rem   = item_q.seq - slot_mul[15:0];
    slot_d     = slot_rem[IDX_W-1:0];
    rtt_prod   = 34'({item_q.rtt_ms, 1'b0}) * 34'(rnrp_pkg::RTT_RECIP);
    rtt_scaled = rtt_prod >> rnrp_pkg::RTT_SHIFT;
    rtt_iv     = rtt_scaled[15:0];
    interval_d = (rtt_iv < cfg_i.min_interval) ? cfg_i.min_interval : rtt_iv;
  end

  // table
  rnrp_pkg::rnrp_entry_t ent_rd, ent_wr;
  logic                  vld_rd, vld_we, vld_wr;
  logic [IDX_W-1:0]      vld_waddr;
  logic                  ent_we;

  rnrp_ram #(
    .WIDTH ($bits(rnrp_pkg::rnrp_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (slot_q),
    .wdata_i (ent_wr),
    .re_i    (cmd_i.addr),
    .raddr_i (slot_d),
    .rdata_o (ent_rd)
  );

  rnrp_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wr),
    .re_i    (cmd_i.addr),
    .raddr_i (slot_d),
    .rdata_o (vld_rd)
  );

  // evaluate stage
  logic                        hit, passed, too_soon, resend_ok;
  logic [rnrp_pkg::CNT_W-1:0]  cur, cnt_inc;
  logic [rnrp_pkg::TIME_W-1:0] base_time, elapsed;
  logic [rnrp_pkg::SEQ_W-1:0]  seq_diff;
  logic                        newer;

  always_comb begin
    hit       = vld_rd && (ent_rd.tag == item_q.seq);
    cur       = hit ? ent_rd.count : '0;
    base_time = hit ? ent_rd.stamp : '0;
    elapsed   = item_q.now_ms - base_time;
    too_soon  = elapsed <= 48'(interval_q);
    cnt_inc   = (cur == rnrp_pkg::CNT_MAX) ? cur : cur + 4'd1;
    passed    = item_q.req_type && !too_old_q && item_q.packet_found && !stale_q;
    resend_ok = passed && (cur < limit_q) && !too_soon;

    result_d.resend   = 1'b0;
    result_d.attempts = cur;
    if (!item_q.req_type) begin
      result_d.outcome  = rnrp_pkg::OC_RECORDED;
      result_d.attempts = '0;
    end else if (too_old_q) begin
      result_d.outcome = rnrp_pkg::OC_TOO_OLD;
    end else if (!item_q.packet_found) begin
      result_d.outcome = rnrp_pkg::OC_MISSING;
    end else if (stale_q) begin
      result_d.outcome = rnrp_pkg::OC_STALE;
    end else if (cur >= limit_q) begin
      result_d.outcome = rnrp_pkg::OC_LIMIT;
    end else if (too_soon) begin
      result_d.outcome = rnrp_pkg::OC_TOO_SOON;
    end else begin
      result_d.outcome  = rnrp_pkg::OC_RESEND;
      result_d.resend   = 1'b1;
      result_d.attempts = cnt_inc;
    end

    // a miss that passes the early checks starts a fresh entry
    ent_we       = cmd_i.eval && passed && (!hit || resend_ok);
    ent_wr.tag   = item_q.seq;
    ent_wr.count = resend_ok ? cnt_inc : '0;
    ent_wr.stamp = resend_ok ? item_q.now_ms : '0;

    vld_we    = cmd_i.clr_en || ent_we;
    vld_waddr = cmd_i.clr_en ? clr_cnt_q : slot_q;
    vld_wr    = !cmd_i.clr_en;

    seq_diff  = item_q.seq - newest_q;
    newer     = (seq_diff == 16'h8000) ? (item_q.seq > newest_q)
                                       : ((seq_diff != '0) && !seq_diff[15]);
    newest_d  = newest_q;
    last_ts_d = last_ts_q;
    if (cmd_i.eval && !item_q.req_type) begin
      if (newer) newest_d = item_q.seq;
      last_ts_d = item_q.media_timestamp;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));
  assign result_o       = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q  <= '0;
      last_ts_q <= '0;
      clr_cnt_q <= '0;
    end else begin
      newest_q  <= newest_d;
      last_ts_q <= last_ts_d;
      if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q    <= item_i;
      quot_q    <= slot_prod[47:32];
      too_old_q <= too_old_d;
      stale_q   <= stale_d;
      limit_q   <= limit_d;
    end
    if (cmd_i.addr) begin
      slot_q     <= slot_d;
      interval_q <= interval_d;
    end
    if (cmd_i.eval) begin
      result_q <= result_d;
    end
  end

endmodule

@@ rtl/core/rtp_nack_retransmit_policy_unit.sv @@
// Flow: a request is accepted in idle; its result is loaded in eval once the
// output register is free. A new request is taken only after the last is
// evaluated (capture, slot reduction and table read, evaluate with entry
// write-back through one RAM write port). Reset: config returns to defaults,
// newest seq and last timestamp clear, and the entry valid RAM is swept over
// all TABLE_DEPTH slots with tready low. Top level of the RTP NACK retransmit
// policy unit; uses rnrp_pkg, rnrp_ctrl, rnrp_dp.
module rtp_nack_retransmit_policy_unit #(
  parameter int unsigned TABLE_DEPTH = rnrp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // seq[15:0] media_timestamp[47:16] packet_found[48] payload_code[55:49]
  // key_flag[56] rtt_ms[72:57] now_ms[120:73], zero pad [127:121]
  input  logic [127:0]                   s_axis_tdata,
  input  logic                           s_axis_tuser,  // req_type[0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // resend[0] outcome[3:1]
                                                        // attempts[7:4]
  // config write port
  input  logic                           cfg_we_i,
  input  logic [rnrp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rnrp_pkg::CFG_W-1:0]     cfg_wdata_i
);

  rnrp_pkg::rnrp_cfg_t    cfg_q, cfg_d;
  rnrp_pkg::rnrp_item_t   item;
  rnrp_pkg::rnrp_result_t result;
  rnrp_pkg::rnrp_cmd_t    cmd;
  rnrp_pkg::rnrp_sts_t    sts;

  // Config register file; writes must come only while the unit is idle, which the block itself does not enforce.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rnrp_pkg::CFG_MAX_AGE:      cfg_d.max_age      = cfg_wdata_i;
        rnrp_pkg::CFG_MIN_INTERVAL: cfg_d.min_interval = cfg_wdata_i;
        rnrp_pkg::CFG_VIDEO_CODE:   cfg_d.video_code   = cfg_wdata_i[6:0];
        rnrp_pkg::CFG_AUDIO_CODE:   cfg_d.audio_code   = cfg_wdata_i[6:0];
        rnrp_pkg::CFG_VIDEO_TPM:    cfg_d.video_tpm    = cfg_wdata_i;
        rnrp_pkg::CFG_AUDIO_TPM:    cfg_d.audio_tpm    = cfg_wdata_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_age      <= '0;
      cfg_q.min_interval <= '0;
      cfg_q.video_code   <= rnrp_pkg::VIDEO_CODE_RST;
      cfg_q.audio_code   <= rnrp_pkg::AUDIO_CODE_RST;
      cfg_q.video_tpm    <= rnrp_pkg::VIDEO_TPM_RST;
      cfg_q.audio_tpm    <= rnrp_pkg::AUDIO_TPM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the request beat.
  always_comb begin
    item.req_type        = s_axis_tuser;
    item.seq             = s_axis_tdata[15:0];
    item.media_timestamp = s_axis_tdata[47:16];
    item.packet_found    = s_axis_tdata[48];
    item.payload_code    = s_axis_tdata[55:49];
    item.key_flag        = s_axis_tdata[56];
    item.rtt_ms          = s_axis_tdata[72:57];
    item.now_ms          = s_axis_tdata[120:73];
  end

  assign m_axis_tdata = {result.attempts, result.outcome, result.resend};

  // Sequencer: clear sweep, then capture -> addr -> eval per request.
  rnrp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Checks, retry table and result register.
  rnrp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .cfg_i    (cfg_q),
    .item_i   (item),
    .sts_o    (sts),
    .result_o (result)
  );

endmodule
